>>> src/resp_multibulk_parser_assert.svh
// Assertion macros shared by the multibulk request parser.
`ifndef RESP_MULTIBULK_PARSER_ASSERT_SVH
`define RESP_MULTIBULK_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RMP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rmp_pkg.sv
// Types, constants and codes for the multibulk request parser.
package rmp_pkg;

  localparam int CNT_W  = 31;
  localparam int LEN_W  = 32;
  localparam int HDR_W  = 17;
  localparam int PROD_W = LEN_W + 4;
  localparam int Q_DEPTH = 4;
  localparam int QP_W    = 2;
  localparam int QC_W    = 3;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [1:0] KIND_PAY = 2'd0;
  localparam logic [1:0] KIND_ARG = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_COUNT = 3'd1;
  localparam logic [2:0] ERR_BAD_LEN   = 3'd2;
  localparam logic [2:0] ERR_INLINE    = 3'd3;
  localparam logic [2:0] ERR_HDR_LONG  = 3'd4;

  localparam logic [1:0] REG_MAX_HDR  = 2'd0;
  localparam logic [1:0] REG_MAX_ARGS = 2'd1;
  localparam logic [1:0] REG_MAX_BULK = 2'd2;

  localparam logic [HDR_W-1:0] MAX_HDR_RST  = 17'd65536;
  localparam logic [CNT_W-1:0] MAX_ARGS_RST = {CNT_W{1'b1}};
  localparam logic [LEN_W-1:0] MAX_BULK_RST = {LEN_W{1'b1}};

  localparam logic [LEN_W-1:0] CNT_CAP = {{(LEN_W-CNT_W){1'b0}}, {CNT_W{1'b1}}};
  localparam logic [LEN_W-1:0] LEN_CAP = {LEN_W{1'b1}};

  typedef struct packed {
    logic [7:0] data;
    logic       is_star;
    logic       is_dollar;
    logic       is_cr;
    logic       is_lf;
    logic       is_digit;
    logic [3:0] digit;
  } tok_t;

  typedef struct packed {
    logic [HDR_W-1:0] max_hdr;
    logic [CNT_W-1:0] max_args;
    logic [LEN_W-1:0] max_bulk;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [CNT_W-1:0] idx;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] total;
    logic             done;
    logic [2:0]       err;
  } res_t;

endpackage

>>> src/rmp_front.sv
// Front end: classifies each incoming byte into a parser token.
module rmp_front (
  input  logic          in_tvalid,
  input  logic          q_ready,
  input  logic [7:0]    in_byte,
  output logic          push,
  output rmp_pkg::tok_t tok
);

  logic [7:0] dig_off;

  assign push    = in_tvalid && q_ready;
  assign dig_off = in_byte - rmp_pkg::CH_ZERO;

  always_comb begin
    tok.data      = in_byte;
    tok.is_star   = (in_byte == rmp_pkg::CH_STAR);
    tok.is_dollar = (in_byte == rmp_pkg::CH_DOLLAR);
    tok.is_cr     = (in_byte == rmp_pkg::CH_CR);
    tok.is_lf     = (in_byte == rmp_pkg::CH_LF);
    tok.is_digit  = (in_byte >= rmp_pkg::CH_ZERO) && (in_byte <= rmp_pkg::CH_NINE);
    tok.digit     = dig_off[3:0];
  end

endmodule

>>> src/rmp_queue.sv
// Short token queue between the front end and the parse engine.
module rmp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rmp_pkg::tok_t push_tok,
  input  logic          pop,
  output logic          not_full,
  output logic          not_empty,
  output rmp_pkg::tok_t head_tok
);

  rmp_pkg::tok_t              mem [rmp_pkg::Q_DEPTH];
  logic [rmp_pkg::QP_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [rmp_pkg::QP_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [rmp_pkg::QC_W-1:0]   count_r, count_nxt;

  assign not_full  = (count_r != rmp_pkg::QC_W'(rmp_pkg::Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_tok  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> src/rmp_back.sv
// Parse engine: runs the request state machine and holds the result register.
module rmp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  rmp_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  rmp_pkg::tok_t tok,
  output logic          q_pop,
  output logic          res_valid_o,
  input  logic          res_ready,
  output rmp_pkg::res_t res_o
);

  localparam logic [3:0] PH_IDLE        = 4'd0;
  localparam logic [3:0] PH_COUNT       = 4'd1;
  localparam logic [3:0] PH_COUNT_LF    = 4'd2;
  localparam logic [3:0] PH_BULK_MARK   = 4'd3;
  localparam logic [3:0] PH_BULK_DIGITS = 4'd4;
  localparam logic [3:0] PH_BULK_LF     = 4'd5;
  localparam logic [3:0] PH_PAYLOAD     = 4'd6;
  localparam logic [3:0] PH_TRAIL1      = 4'd7;
  localparam logic [3:0] PH_TRAIL2      = 4'd8;
  localparam logic [3:0] PH_ERROR       = 4'd9;

  logic [3:0]                 phase_r, phase_nxt;
  logic [rmp_pkg::LEN_W-1:0]  acc_r, acc_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [rmp_pkg::HDR_W-1:0]  hdr_r, hdr_nxt;
  logic [rmp_pkg::CNT_W-1:0]  total_r, total_nxt;
  logic [rmp_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic [rmp_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [rmp_pkg::LEN_W-1:0]  remain_r, remain_nxt;
  logic [2:0]                 err_r, err_nxt;
  logic                       out_valid_r, out_valid_nxt;
  rmp_pkg::res_t              out_r, out_nxt;

  logic                       go;
  logic                       res_valid;
  logic [1:0]                 res_kind;
  logic [7:0]                 res_data;
  logic                       res_done;
  logic [2:0]                 fail_code;
  logic [rmp_pkg::LEN_W-1:0]  cap;
  logic [rmp_pkg::PROD_W-1:0] prod;
  logic                       ovf_step;
  logic                       hdr_over;
  logic                       last_arg;

  assign go    = q_valid && (!out_valid_r || res_ready);
  assign q_pop = go;

  assign cap  = (phase_r == PH_COUNT) ? rmp_pkg::CNT_CAP : rmp_pkg::LEN_CAP;
  assign prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
              + {{(rmp_pkg::PROD_W-4){1'b0}}, tok.digit};
  assign ovf_step = prod > {4'b0000, cap};
  assign hdr_over = ({1'b0, hdr_r} + 1'b1) > {1'b0, cfg.max_hdr};
  assign last_arg = ({1'b0, idx_r} + 1'b1) >= {1'b0, total_r};

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    hdr_nxt    = hdr_r;
    total_nxt  = total_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    remain_nxt = remain_r;
    err_nxt    = err_r;
    res_valid  = 1'b0;
    res_kind   = rmp_pkg::KIND_PAY;
    res_data   = '0;
    res_done   = 1'b0;
    fail_code  = rmp_pkg::ERR_NONE;
    case (phase_r)
      PH_IDLE: begin
        if (!tok.is_star) begin
          fail_code = rmp_pkg::ERR_INLINE;
        end else begin
          acc_nxt   = '0;
          ovf_nxt   = 1'b0;
          hdr_nxt   = '0;
          total_nxt = '0;
          idx_nxt   = '0;
          len_nxt   = '0;
          phase_nxt = PH_COUNT;
        end
      end
      PH_COUNT, PH_BULK_DIGITS: begin
        if (tok.is_cr) begin
          if (phase_r == PH_COUNT) begin
            if (hdr_r == '0 || ovf_r || acc_r == '0 ||
                acc_r > {1'b0, cfg.max_args}) begin
              fail_code = rmp_pkg::ERR_BAD_COUNT;
            end else begin
              total_nxt = acc_r[rmp_pkg::CNT_W-1:0];
              phase_nxt = PH_COUNT_LF;
            end
          end else begin
            if (hdr_r == '0 || ovf_r || acc_r > cfg.max_bulk) begin
              fail_code = rmp_pkg::ERR_BAD_LEN;
            end else begin
              len_nxt   = acc_r;
              phase_nxt = PH_BULK_LF;
            end
          end
        end else if (hdr_over) begin
          fail_code = rmp_pkg::ERR_HDR_LONG;
        end else if (!tok.is_digit) begin
          fail_code = (phase_r == PH_COUNT) ? rmp_pkg::ERR_BAD_COUNT : rmp_pkg::ERR_BAD_LEN;
        end else begin
          hdr_nxt = hdr_r + 1'b1;
          ovf_nxt = ovf_r | ovf_step;
          acc_nxt = ovf_step ? cap : prod[rmp_pkg::LEN_W-1:0];
        end
      end
      PH_COUNT_LF: begin
        phase_nxt = PH_BULK_MARK;
      end
      PH_BULK_MARK: begin
        if (!tok.is_dollar) begin
          fail_code = rmp_pkg::ERR_BAD_LEN;
        end else begin
          acc_nxt   = '0;
          ovf_nxt   = 1'b0;
          hdr_nxt   = '0;
          phase_nxt = PH_BULK_DIGITS;
        end
      end
      PH_BULK_LF: begin
        if (!tok.is_lf) begin
          fail_code = rmp_pkg::ERR_BAD_LEN;
        end else begin
          remain_nxt = len_r;
          phase_nxt  = (len_r == '0) ? PH_TRAIL1 : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        remain_nxt = remain_r - 1'b1;
        if (remain_r == rmp_pkg::LEN_W'(1)) begin
          phase_nxt = PH_TRAIL1;
        end
        res_valid = 1'b1;
        res_kind  = rmp_pkg::KIND_PAY;
        res_data  = tok.data;
      end
      PH_TRAIL1: begin
        phase_nxt = PH_TRAIL2;
      end
      PH_TRAIL2: begin
        res_valid = 1'b1;
        res_kind  = rmp_pkg::KIND_ARG;
        res_done  = last_arg;
        if (last_arg) begin
          phase_nxt = PH_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          phase_nxt = PH_BULK_MARK;
        end
      end
      PH_ERROR: begin
        res_valid = 1'b1;
        res_kind  = rmp_pkg::KIND_ERR;
      end
      default: begin
        phase_nxt = PH_ERROR;
        if (err_r == rmp_pkg::ERR_NONE) begin
          err_nxt = rmp_pkg::ERR_INLINE;
        end
        res_valid = 1'b1;
        res_kind  = rmp_pkg::KIND_ERR;
      end
    endcase
    if (fail_code != rmp_pkg::ERR_NONE) begin
      err_nxt   = fail_code;
      phase_nxt = PH_ERROR;
      res_valid = 1'b1;
      res_kind  = rmp_pkg::KIND_ERR;
      res_data  = '0;
      res_done  = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !res_ready;
    out_nxt       = out_r;
    if (go && res_valid) begin
      out_valid_nxt = 1'b1;
      out_nxt.kind  = res_kind;
      out_nxt.data  = res_data;
      out_nxt.done  = res_done;
      if (res_kind == rmp_pkg::KIND_ERR) begin
        out_nxt.idx   = '0;
        out_nxt.len   = '0;
        out_nxt.total = '0;
        out_nxt.err   = err_nxt;
      end else begin
        out_nxt.idx   = idx_r;
        out_nxt.len   = len_r;
        out_nxt.total = total_r;
        out_nxt.err   = rmp_pkg::ERR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      err_r       <= rmp_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        phase_r <= phase_nxt;
        err_r   <= err_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
      hdr_r    <= hdr_nxt;
      total_r  <= total_nxt;
      idx_r    <= idx_nxt;
      len_r    <= len_nxt;
      remain_r <= remain_nxt;
    end
    out_r <= out_nxt;
  end

  assign res_valid_o = out_valid_r;
  assign res_o       = out_r;

endmodule

>>> src/resp_multibulk_parser.sv
// Top level of the multibulk request parser with its configuration registers.
// A byte accepted at the input is written into the token queue, and any result it yields
// is then registered in the output register that drives out_tvalid.
// Throughput is one byte per cycle while the output register is free or being read.
// A four-entry token queue lets the input keep flowing while the output stalls.
// Synchronous active-low reset returns the parser to idle, clears the sticky error,
// empties the queue, sets the header limit to 65536 and the other limits to their maxima.
module resp_multibulk_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0: in_byte[7:0].
  input  logic [7:0]   in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // Fields from bit 0: data_byte[7:0], arg_index[38:8], arg_length[70:39],
  // arg_total[101:71], err_code[104:102], zero fill[111:105].
  output logic [111:0] out_tdata,
  // Fields from bit 0: kind[1:0].
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  rmp_pkg::cfg_t cfg_r, cfg_nxt;
  logic          cfg_wr;
  logic          push;
  logic          q_not_full;
  logic          q_not_empty;
  logic          q_pop;
  rmp_pkg::tok_t in_tok;
  rmp_pkg::tok_t head_tok;
  rmp_pkg::res_t res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_paddr[3:2])
        rmp_pkg::REG_MAX_HDR:  cfg_nxt.max_hdr  = cfg_pwdata[rmp_pkg::HDR_W-1:0];
        rmp_pkg::REG_MAX_ARGS: cfg_nxt.max_args = cfg_pwdata[rmp_pkg::CNT_W-1:0];
        rmp_pkg::REG_MAX_BULK: cfg_nxt.max_bulk = cfg_pwdata[rmp_pkg::LEN_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      rmp_pkg::REG_MAX_HDR:  cfg_prdata = {{(32-rmp_pkg::HDR_W){1'b0}}, cfg_r.max_hdr};
      rmp_pkg::REG_MAX_ARGS: cfg_prdata = {{(32-rmp_pkg::CNT_W){1'b0}}, cfg_r.max_args};
      rmp_pkg::REG_MAX_BULK: cfg_prdata = cfg_r.max_bulk;
      default:               cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_hdr  <= rmp_pkg::MAX_HDR_RST;
      cfg_r.max_args <= rmp_pkg::MAX_ARGS_RST;
      cfg_r.max_bulk <= rmp_pkg::MAX_BULK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = q_not_full;

  rmp_front u_front (
    .in_tvalid (in_tvalid),
    .q_ready   (q_not_full),
    .in_byte   (in_tdata),
    .push      (push),
    .tok       (in_tok)
  );

  rmp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_tok  (in_tok),
    .pop       (q_pop),
    .not_full  (q_not_full),
    .not_empty (q_not_empty),
    .head_tok  (head_tok)
  );

  rmp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_valid     (q_not_empty),
    .tok         (head_tok),
    .q_pop       (q_pop),
    .res_valid_o (out_tvalid),
    .res_ready   (out_tready),
    .res_o       (res)
  );

  assign out_tdata = {7'b0000000, res.err, res.total, res.len, res.idx, res.data};
  assign out_tuser = res.kind;
  assign out_tlast = res.done;

`include "resp_multibulk_parser_assert.svh"

  `RMP_ASSERT_NXT(a_error_sticky, out_tvalid && out_tuser == rmp_pkg::KIND_ERR,
    !out_tvalid || out_tuser == rmp_pkg::KIND_ERR, "error word followed by a non-error word")
  `RMP_ASSERT_IMP(a_err_code_kind, out_tvalid,
    (out_tuser == rmp_pkg::KIND_ERR) == (out_tdata[104:102] != rmp_pkg::ERR_NONE),
    "error code does not match kind")
  `RMP_ASSERT_IMP(a_index_in_range, out_tvalid && out_tuser != rmp_pkg::KIND_ERR,
    out_tdata[38:8] < out_tdata[101:71], "argument index not below argument total")

endmodule
